### rtl/kv_request_batch_scheduler_macros.svh
// Assertion macros for the request batch scheduler.
`ifndef KV_REQUEST_BATCH_SCHEDULER_MACROS_SVH
`define KV_REQUEST_BATCH_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define KVS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KVS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define KVS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/kvs_pkg.sv
`default_nettype none
package kvs_pkg;
  localparam int QueueDepth = 32;
  localparam int QueueAw = $clog2(QueueDepth);
  localparam int QueueCw = QueueAw + 1;
  localparam int OutstandingMax = 4096;
  localparam int OwedW = 13;
  localparam int ResultCap = 32;
  localparam int CfgW = 16;
  localparam int CfgIdxW = 3;

  typedef enum logic [2:0] {
    OP_ARRIVAL = 3'd0, OP_READ_DONE = 3'd1, OP_BATCH_DONE = 3'd2,
    OP_TICK = 3'd3, OP_CLEAN = 3'd4, OP_LINK_FAIL = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    RT_PARAMS = 4'd0, RT_GET = 4'd1, RT_RANGE = 4'd2, RT_SET = 4'd3,
    RT_CAS = 4'd6, RT_CAD = 4'd8
  } rtype_t;

  typedef enum logic [2:0] {
    RK_READ = 3'd0, RK_WRITE = 3'd1, RK_EMPTY = 3'd2, RK_PARAMS = 3'd3,
    RK_DROP = 3'd4, RK_REFUSE = 3'd5, RK_NONE = 3'd6
  } rkind_t;

  typedef enum logic [2:0] {
    CFG_KEY = 3'd0, CFG_VALUE = 3'd1, CFG_RBUDGET = 3'd2, CFG_WBUDGET = 3'd3,
    CFG_MINB = 3'd4, CFG_TIMEOUT = 3'd5, CFG_RANGE = 3'd6, CFG_OUTST = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READS, ST_BCHECK, ST_BDIV, ST_BATCH, ST_TIMER, ST_EMIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  request_type;
    logic [31:0] request_id;
    logic [7:0]  key_length;
    logic [7:0]  value_length;
    logic [3:0]  read_tree_height;
    logic [3:0]  write_tree_height;
    logic [15:0] released_pages;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] launched_id;
    logic [3:0]  launched_type;
    logic [15:0] pages_charged;
    logic        run_last;
  } res_t;
endpackage
`default_nettype wire

### rtl/kvs_stream_if.sv
`default_nettype none
interface kvs_stream_if #(type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/kv_request_batch_scheduler.sv
// Request batch scheduler. One event is taken on req, its results leave on res in
// order, run_last marking the final one. A stalled result port holds the sequencer,
// and a write batch whose pages exceed the budget first runs a shift-subtract
// division of the write page budget by pages per operation. All work runs through
// one sequencer and one adder/comparator datapath, one queue entry per launch.
// Queue memories need no clearing after reset.
`default_nettype none
`include "kv_request_batch_scheduler_macros.svh"
module kv_request_batch_scheduler
  import kvs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  kvs_stream_if.sink               req,
  kvs_stream_if.source             res,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]     cfg_data
);
  logic [7:0]  key_limit, value_limit, range_extra_pages;
  logic [15:0] read_page_budget, write_page_budget, batch_timeout_ticks;
  logic [12:0] min_batch, outstanding_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit <= 8'd255; value_limit <= 8'd255;
      read_page_budget <= 16'd256; write_page_budget <= 16'd256;
      min_batch <= 13'd1; batch_timeout_ticks <= '0;
      range_extra_pages <= 8'd8; outstanding_limit <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY:     key_limit <= cfg_data[7:0];
        CFG_VALUE:   value_limit <= cfg_data[7:0];
        CFG_RBUDGET: read_page_budget <= cfg_data;
        CFG_WBUDGET: write_page_budget <= cfg_data;
        CFG_MINB:    min_batch <= cfg_data[12:0];
        CFG_TIMEOUT: batch_timeout_ticks <= cfg_data;
        CFG_RANGE:   range_extra_pages <= cfg_data[7:0];
        CFG_OUTST:   outstanding_limit <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [32:0] rq_mem [QueueDepth];
  logic [35:0] wq_mem [QueueDepth];
  logic [QueueAw-1:0] rq_head, wq_head;
  logic [QueueCw-1:0] rq_count, wq_count;
  logic [15:0] pages_in_flight;
  logic [OwedW-1:0] owed;
  logic batch_running;
  logic [QueueCw-1:0] batch_count;
  logic timer_running, timer_expired, cleaning_pending, link_dying;
  logic [15:0] timer_remaining;

  state_t state;
  req_t cur;
  res_t out_r;
  res_t hold;
  res_t pend;
  logic pend_valid;
  logic pend_load;
  logic emitted;
  logic [5:0] launched;
  logic [QueueCw-1:0] bsize, bleft;
  logic [16:0] rem;
  logic [15:0] quo;
  logic [4:0] div_step;
  state_t after_emit;
  logic [32:0] rq_rd;
  logic [35:0] wq_rd;

  assign rq_rd = rq_mem[rq_head];
  assign wq_rd = wq_mem[wq_head];

  // shared datapath values
  logic is_range;
  logic [15:0] rpages;
  logic [16:0] rsum;
  logic [4:0] ppo;
  logic [20:0] wneed;
  logic bcond;
  logic [16:0] trial;

  always_comb begin
    is_range = rq_rd[32];
    rpages = is_range ? (16'(cur.read_tree_height) + 16'(range_extra_pages))
                      : (16'(cur.read_tree_height) + 16'd1);
    rsum = 17'(pages_in_flight) + 17'(rpages);
    ppo = 5'(cur.write_tree_height) + 5'd1;
    wneed = 21'(wq_count) * 21'(ppo);
    bcond = !batch_running && (timer_expired || cleaning_pending ||
            13'(wq_count) >= min_batch);
    trial = {rem[15:0], write_page_budget[15 - div_step[3:0]]} - 17'(ppo);
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rq_head <= '0; wq_head <= '0; rq_count <= '0; wq_count <= '0;
      pages_in_flight <= '0; owed <= '0; batch_running <= 1'b0; batch_count <= '0;
      timer_running <= 1'b0; timer_expired <= 1'b0; timer_remaining <= '0;
      cleaning_pending <= 1'b0; link_dying <= 1'b0;
      emitted <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            emitted <= 1'b0;
            launched <= '0;
            case (op_t'(req.data.operation))
              OP_ARRIVAL: begin
                if (link_dying || owed >= outstanding_limit ||
                    32'(owed) >= OutstandingMax) begin
                  out_r <= '{result_kind: RK_REFUSE, launched_id: req.data.request_id,
                             launched_type: req.data.request_type, pages_charged: '0,
                             run_last: 1'b0};
                  state <= ST_EMIT; after_emit <= ST_DONE;
                end else if (req.data.request_type == RT_PARAMS) begin
                  out_r <= '{result_kind: RK_PARAMS, launched_id: req.data.request_id,
                             launched_type: '0, pages_charged: '0, run_last: 1'b0};
                  state <= ST_EMIT; after_emit <= ST_DONE;
                end else if (req.data.request_type == RT_GET ||
                             req.data.request_type == RT_RANGE) begin
                  if (32'(rq_count) >= QueueDepth) begin
                    out_r <= '{result_kind: RK_REFUSE, launched_id: req.data.request_id,
                               launched_type: req.data.request_type, pages_charged: '0,
                               run_last: 1'b0};
                    state <= ST_EMIT; after_emit <= ST_DONE;
                  end else begin
                    rq_mem[QueueAw'(rq_head + QueueAw'(rq_count))] <=
                      {req.data.request_type == RT_RANGE, req.data.request_id};
                    rq_count <= rq_count + 1'b1;
                    owed <= owed + 1'b1;
                    state <= ST_READS;
                  end
                end else if (req.data.request_type >= RT_SET &&
                             req.data.request_type <= RT_CAD) begin
                  if (req.data.request_type <= RT_CAS &&
                      (req.data.key_length > key_limit ||
                       req.data.value_length > value_limit)) begin
                    link_dying <= 1'b1;
                    owed <= (32'(owed) > 32'(rq_count) + 32'(wq_count)) ?
                            OwedW'(32'(owed) - 32'(rq_count) - 32'(wq_count)) : '0;
                    rq_count <= '0; wq_count <= '0; rq_head <= '0; wq_head <= '0;
                    timer_running <= 1'b0; timer_remaining <= '0; timer_expired <= 1'b0;
                    out_r <= '{result_kind: RK_DROP, launched_id: req.data.request_id,
                               launched_type: req.data.request_type, pages_charged: '0,
                               run_last: 1'b0};
                    state <= ST_EMIT; after_emit <= ST_DONE;
                  end else if (32'(wq_count) >= QueueDepth) begin
                    out_r <= '{result_kind: RK_REFUSE, launched_id: req.data.request_id,
                               launched_type: req.data.request_type, pages_charged: '0,
                               run_last: 1'b0};
                    state <= ST_EMIT; after_emit <= ST_DONE;
                  end else begin
                    wq_mem[QueueAw'(wq_head + QueueAw'(wq_count))] <=
                      {req.data.request_type, req.data.request_id};
                    wq_count <= wq_count + 1'b1;
                    owed <= owed + 1'b1;
                    state <= ST_BCHECK;
                  end
                end else begin
                  link_dying <= 1'b1;
                  owed <= (32'(owed) > 32'(rq_count) + 32'(wq_count)) ?
                          OwedW'(32'(owed) - 32'(rq_count) - 32'(wq_count)) : '0;
                  rq_count <= '0; wq_count <= '0; rq_head <= '0; wq_head <= '0;
                  timer_running <= 1'b0; timer_remaining <= '0; timer_expired <= 1'b0;
                  out_r <= '{result_kind: RK_DROP, launched_id: req.data.request_id,
                             launched_type: req.data.request_type, pages_charged: '0,
                             run_last: 1'b0};
                  state <= ST_EMIT; after_emit <= ST_DONE;
                end
              end
              OP_READ_DONE: begin
                pages_in_flight <= (pages_in_flight > req.data.released_pages) ?
                                   pages_in_flight - req.data.released_pages : '0;
                owed <= (owed != '0) ? owed - 1'b1 : '0;
                state <= ST_READS;
              end
              OP_BATCH_DONE: begin
                if (batch_running) begin
                  owed <= (owed > OwedW'(batch_count)) ? owed - OwedW'(batch_count) : '0;
                  batch_running <= 1'b0;
                  batch_count <= '0;
                  state <= ST_BCHECK;
                end else begin
                  state <= ST_DONE;
                end
              end
              OP_TICK: begin
                if (timer_running && timer_remaining <= 16'd1) begin
                  timer_remaining <= '0; timer_running <= 1'b0; timer_expired <= 1'b1;
                  state <= ST_BCHECK;
                end else if (timer_running) begin
                  timer_remaining <= timer_remaining - 1'b1;
                  state <= ST_DONE;
                end else begin
                  state <= ST_DONE;
                end
              end
              OP_CLEAN: begin
                cleaning_pending <= 1'b1;
                state <= ST_BCHECK;
              end
              OP_LINK_FAIL: begin
                link_dying <= 1'b1;
                owed <= (32'(owed) > 32'(rq_count) + 32'(wq_count)) ?
                        OwedW'(32'(owed) - 32'(rq_count) - 32'(wq_count)) : '0;
                rq_count <= '0; wq_count <= '0; rq_head <= '0; wq_head <= '0;
                timer_running <= 1'b0; timer_remaining <= '0; timer_expired <= 1'b0;
                out_r <= '{result_kind: RK_DROP, launched_id: '0, launched_type: '0,
                           pages_charged: '0, run_last: 1'b0};
                state <= ST_EMIT; after_emit <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_READS: begin
          if (rq_count != '0 && 32'(launched) < ResultCap &&
              !(pages_in_flight != '0 && rsum > 17'(read_page_budget))) begin
            rq_head <= rq_head + 1'b1;
            rq_count <= rq_count - 1'b1;
            pages_in_flight <= rsum[16] ? 16'hFFFF : rsum[15:0];
            launched <= launched + 1'b1;
            out_r <= '{result_kind: RK_READ, launched_id: rq_rd[31:0],
                       launched_type: is_range ? RT_RANGE : RT_GET,
                       pages_charged: rpages, run_last: 1'b0};
            state <= ST_EMIT; after_emit <= ST_READS;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_BCHECK: begin
          if (bcond) begin
            if (wneed > 21'(write_page_budget)) begin
              rem <= '0; quo <= '0; div_step <= '0;
              state <= ST_BDIV;
            end else begin
              bsize <= wq_count; bleft <= wq_count;
              state <= ST_BATCH;
            end
            batch_running <= 1'b1;
            timer_running <= 1'b0; timer_remaining <= '0;
            timer_expired <= 1'b0; cleaning_pending <= 1'b0;
          end else begin
            state <= ST_TIMER;
          end
        end
        ST_BDIV: begin
          if (div_step == 5'd16) begin
            // quotient is below count here, which is at most the depth
            bsize <= QueueCw'(quo); bleft <= QueueCw'(quo);
            state <= ST_BATCH;
          end else begin
            if (!trial[16]) begin
              rem <= trial; quo <= {quo[14:0], 1'b1};
            end else begin
              rem <= {rem[15:0], write_page_budget[15 - div_step[3:0]]};
              quo <= {quo[14:0], 1'b0};
            end
            div_step <= div_step + 1'b1;
          end
        end
        ST_BATCH: begin
          batch_count <= bsize;
          if (bleft != '0) begin
            wq_head <= wq_head + 1'b1;
            wq_count <= wq_count - 1'b1;
            bleft <= bleft - 1'b1;
            out_r <= '{result_kind: RK_WRITE, launched_id: wq_rd[31:0],
                       launched_type: wq_rd[35:32], pages_charged: '0, run_last: 1'b0};
            state <= ST_EMIT; after_emit <= ST_BATCH;
          end else if (bsize == '0) begin
            out_r <= '{result_kind: RK_EMPTY, launched_id: '0, launched_type: '0,
                       pages_charged: '0, run_last: 1'b0};
            bsize <= QueueCw'(1);
            state <= ST_EMIT; after_emit <= ST_TIMER;
          end else begin
            state <= ST_TIMER;
          end
        end
        ST_TIMER: begin
          if (!timer_running && !timer_expired && wq_count != '0) begin
            timer_running <= 1'b1;
            timer_remaining <= batch_timeout_ticks;
          end
          if (after_emit == ST_TIMER) batch_count <= '0;
          after_emit <= ST_DONE;
          state <= ST_DONE;
        end
        ST_EMIT: begin
          if (!emitted || !pend_valid || res.ready) begin
            hold <= out_r;
            emitted <= 1'b1;
            state <= after_emit;
          end
        end
        ST_DONE: begin
          if (!pend_valid || res.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // hold the newest result; a new one is loaded only once the prior one is taken or absent
  assign pend_load = (!pend_valid || res.ready) &&
                     ((state == ST_EMIT && emitted) || state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_load) begin
      pend_valid <= 1'b1;
      if (state == ST_EMIT)
        pend <= hold;
      else if (emitted)
        pend <= '{result_kind: hold.result_kind, launched_id: hold.launched_id,
                  launched_type: hold.launched_type, pages_charged: hold.pages_charged,
                  run_last: 1'b1};
      else
        pend <= '{result_kind: RK_NONE, launched_id: '0, launched_type: '0,
                  pages_charged: '0, run_last: 1'b1};
    end else if (res.ready) begin
      pend_valid <= 1'b0;
    end
  end

  assign res.valid = pend_valid;
  assign res.data = pend;

  `KVS_ASSERT_IMPL(a_ready_idle, clk, rst, req.ready, !pend_valid || res.valid)
  `KVS_ASSERT_IMPL(a_counts, clk, rst, 1'b1,
                   32'(rq_count) <= QueueDepth && 32'(wq_count) <= QueueDepth)
  `KVS_ASSERT_NEXT(a_drop_flush, clk, rst,
                   req.valid && req.ready && req.data.operation == OP_LINK_FAIL,
                   rq_count == '0 && wq_count == '0 && link_dying)
endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
import kvs_pkg::*;

class sched_board;
  int unsigned key_lim, val_lim, rd_budget, wr_budget, min_bat, timeout, range_extra, owed_lim;
  logic [32:0] read_q[$];
  logic [35:0] write_q[$];
  int unsigned pif, owed, batch_cnt, timer_left;
  bit batch_on, timer_on, timer_exp, clean_pend, dying;
  res_t step_out[$];
  res_t launches[$];
  int errors;

  function new();
    key_lim = 255; val_lim = 255; rd_budget = 256; wr_budget = 256;
    min_bat = 1; timeout = 0; range_extra = 8; owed_lim = 4096;
    pif = 0; owed = 0; batch_cnt = 0; timer_left = 0;
    batch_on = 0; timer_on = 0; timer_exp = 0; clean_pend = 0; dying = 0;
    errors = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [15:0] v);
    case (idx)
      CFG_KEY: key_lim = v[7:0];
      CFG_VALUE: val_lim = v[7:0];
      CFG_RBUDGET: rd_budget = v;
      CFG_WBUDGET: wr_budget = v;
      CFG_MINB: min_bat = v[12:0];
      CFG_TIMEOUT: timeout = v;
      CFG_RANGE: range_extra = v[7:0];
      CFG_OUTST: owed_lim = v[12:0];
      default: ;
    endcase
  endfunction

  function int outstanding();
    return launches.size();
  endfunction

  function void emit(rkind_t kind, logic [31:0] id, logic [3:0] rt, int unsigned pages);
    res_t o;
    if (step_out.size() >= ResultCap) return;
    o.result_kind = kind;
    o.launched_id = id;
    o.launched_type = rt;
    o.pages_charged = pages[15:0];
    o.run_last = 1'b0;
    step_out.push_back(o);
  endfunction

  function void launch_reads(int unsigned h);
    int unsigned n, pages;
    logic [32:0] e;
    n = 0;
    while (read_q.size() > 0 && n < ResultCap) begin
      e = read_q[0];
      pages = e[32] ? h + range_extra : h + 1;
      if (pif > 0 && pif + pages > rd_budget) break;
      void'(read_q.pop_front());
      pif += pages;
      if (pif > 16'hFFFF) pif = 16'hFFFF;
      emit(RK_READ, e[31:0], e[32] ? RT_RANGE : RT_GET, pages);
      n++;
    end
  endfunction

  function void launch_batch(int unsigned h);
    int unsigned ppo, size;
    logic [35:0] e;
    if (!batch_on && (timer_exp || clean_pend || write_q.size() >= min_bat)) begin
      ppo = h + 1;
      if (write_q.size() * ppo > wr_budget) size = wr_budget / ppo;
      else size = write_q.size();
      if (size > ResultCap) size = ResultCap;
      for (int i = 0; i < size; i++) begin
        e = write_q.pop_front();
        emit(RK_WRITE, e[31:0], e[35:32], 0);
      end
      if (size == 0) emit(RK_EMPTY, 0, 0, 0);
      batch_on = 1;
      batch_cnt = size;
      timer_on = 0;
      timer_left = 0;
      timer_exp = 0;
      clean_pend = 0;
    end
    if (!timer_on && !timer_exp && write_q.size() > 0) begin
      timer_on = 1;
      timer_left = timeout;
    end
  endfunction

  function void drop_link(logic [31:0] id, logic [3:0] rt);
    int unsigned queued;
    queued = read_q.size() + write_q.size();
    dying = 1;
    owed = owed > queued ? owed - queued : 0;
    read_q.delete();
    write_q.delete();
    timer_on = 0;
    timer_left = 0;
    timer_exp = 0;
    emit(RK_DROP, id, rt, 0);
  endfunction

  function void note_request(req_t r);
    int unsigned t;
    step_out.delete();
    t = r.request_type;
    case (r.operation)
      OP_ARRIVAL: begin
        if (dying || owed >= owed_lim || owed >= OutstandingMax) begin
          emit(RK_REFUSE, r.request_id, r.request_type, 0);
        end else if (t == RT_PARAMS) begin
          emit(RK_PARAMS, r.request_id, 0, 0);
        end else if (t == RT_GET || t == RT_RANGE) begin
          if (read_q.size() >= QueueDepth) begin
            emit(RK_REFUSE, r.request_id, r.request_type, 0);
          end else begin
            read_q.push_back({t == RT_RANGE, r.request_id});
            owed++;
            launch_reads(r.read_tree_height);
          end
        end else if (t >= RT_SET && t <= RT_CAD) begin
          if (t <= RT_CAS && (r.key_length > key_lim || r.value_length > val_lim)) begin
            drop_link(r.request_id, r.request_type);
          end else if (write_q.size() >= QueueDepth) begin
            emit(RK_REFUSE, r.request_id, r.request_type, 0);
          end else begin
            write_q.push_back({r.request_type, r.request_id});
            owed++;
            launch_batch(r.write_tree_height);
          end
        end else begin
          drop_link(r.request_id, r.request_type);
        end
      end
      OP_READ_DONE: begin
        pif = pif > r.released_pages ? pif - r.released_pages : 0;
        owed = owed > 0 ? owed - 1 : 0;
        launch_reads(r.read_tree_height);
      end
      OP_BATCH_DONE: begin
        if (batch_on) begin
          owed = owed > batch_cnt ? owed - batch_cnt : 0;
          batch_on = 0;
          batch_cnt = 0;
          launch_batch(r.write_tree_height);
        end
      end
      OP_TICK: begin
        if (timer_on) begin
          if (timer_left <= 1) begin
            timer_left = 0;
            timer_on = 0;
            timer_exp = 1;
            launch_batch(r.write_tree_height);
          end else begin
            timer_left--;
          end
        end
      end
      OP_CLEAN: begin
        clean_pend = 1;
        launch_batch(r.write_tree_height);
      end
      OP_LINK_FAIL: drop_link(0, 0);
      default: ;
    endcase
    if (step_out.size() == 0) emit(RK_NONE, 0, 0, 0);
    step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i]) launches.push_back(step_out[i]);
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void check_result(res_t a);
    res_t e;
    if (launches.size() == 0) begin
      report($sformatf("unexpected result kind=%0d id=%h", a.result_kind, a.launched_id));
      return;
    end
    e = launches.pop_front();
    if (a.result_kind !== e.result_kind)
      report($sformatf("result_kind exp %0d got %0d", e.result_kind, a.result_kind));
    if (a.launched_id !== e.launched_id)
      report($sformatf("launched_id exp %h got %h", e.launched_id, a.launched_id));
    if (a.launched_type !== e.launched_type)
      report($sformatf("launched_type exp %0d got %0d", e.launched_type, a.launched_type));
    if (a.pages_charged !== e.pages_charged)
      report($sformatf("pages_charged exp %0d got %0d", e.pages_charged, a.pages_charged));
    if (a.run_last !== e.run_last)
      report($sformatf("run_last exp %0d got %0d", e.run_last, a.run_last));
  endfunction
endclass

module tb_top;
  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int cycles = 0;
  sched_board sb = new();

  kvs_stream_if #(.payload_t(req_t)) req_if ();
  kvs_stream_if #(.payload_t(res_t)) res_if ();

  kv_request_batch_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .res(res_if.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    res_if.ready = !rst && !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(int k, int v, int rb, int wb, int mb, int tmo, int rx, int ol);
    write_reg(CFG_KEY, 16'(k));
    write_reg(CFG_VALUE, 16'(v));
    write_reg(CFG_RBUDGET, 16'(rb));
    write_reg(CFG_WBUDGET, 16'(wb));
    write_reg(CFG_MINB, 16'(mb));
    write_reg(CFG_TIMEOUT, 16'(tmo));
    write_reg(CFG_RANGE, 16'(rx));
    write_reg(CFG_OUTST, 16'(ol));
  endtask

  task automatic send(req_t r, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.data = r;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic req_t mk(op_t op, logic [3:0] rt, logic [31:0] id,
                              logic [7:0] kl, logic [7:0] vl, logic [3:0] rh,
                              logic [3:0] wh, logic [15:0] rel);
    req_t r;
    r.operation = op;
    r.request_type = rt;
    r.request_id = id;
    r.key_length = kl;
    r.value_length = vl;
    r.read_tree_height = rh;
    r.write_tree_height = wh;
    r.released_pages = rel;
    return r;
  endfunction

  function automatic req_t rand_item();
    req_t r;
    int pick;
    int unsigned t;
    r = mk(OP_ARRIVAL, 0, $urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
           16'($urandom_range(1, 24)));
    pick = $urandom_range(99);
    if (pick < 55) begin
      t = $urandom_range(0, 8);
      r.request_type = 4'(t);
      if (t >= RT_SET && t <= RT_CAS) begin
        r.key_length = 8'($urandom_range(0, sb.key_lim));
        r.value_length = 8'($urandom_range(0, sb.val_lim));
      end
    end else if (pick < 72) begin
      r.operation = OP_READ_DONE;
      if ($urandom_range(9) == 0) r.released_pages = 16'($urandom_range(0, 65535));
    end else if (pick < 84) r.operation = OP_BATCH_DONE;
    else if (pick < 93) r.operation = OP_TICK;
    else if (pick < 97) r.operation = OP_CLEAN;
    else r.operation = op_t'($urandom_range(6, 7));
    return r;
  endfunction

  task automatic run_phase(int idle_pct, int stall, bit squeeze, int n);
    stall_pct = stall;
    if (squeeze) begin
      fork
        begin
          hold_off = 1'b1;
          repeat (400) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
    end
    repeat (n) send(rand_item(), idle_pct);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send(mk(OP_ARRIVAL, RT_PARAMS, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, RT_GET, 32'h0000_0001, 0, 0, 15, 0, 0), 0);
    send(mk(OP_ARRIVAL, RT_RANGE, 32'hA5A5_5A5A, 0, 0, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, RT_SET, 32'h1234_5678, 255, 255, 0, 15, 0), 0);
    send(mk(OP_BATCH_DONE, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, 4'd4, 32'h0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, 4'd5, 32'h5, 255, 0, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, RT_CAS, 32'h6, 0, 255, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, 4'd7, 32'h7, 255, 255, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, RT_CAD, 32'h8, 255, 255, 0, 0, 0), 0);
    send(mk(OP_BATCH_DONE, 0, 0, 0, 0, 0, 3, 0), 0);
    send(mk(OP_BATCH_DONE, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_CLEAN, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_READ_DONE, 0, 0, 0, 0, 15, 0, 16'hFFFF), 0);
    send(mk(OP_READ_DONE, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(op_t'(3'd6), 4'hF, 32'hFFFF_FFFF, 255, 255, 15, 15, 16'hFFFF), 0);
    send(mk(op_t'(3'd7), 0, 0, 0, 0, 0, 0, 0), 0);
    drain();

    set_all(255, 255, 256, 256, 1, 0, 8, 4096);
    run_phase(0, 0, 1'b1, 50);
    set_all(0, 0, 1, 1, 0, 1, 0, 1);
    run_phase(73, 0, 1'b0, 50);
    set_all(100, 200, 65535, 65535, 4096, 65535, 255, 4096);
    run_phase(0, 73, 1'b0, 50);
    set_all(255, 255, 40, 30, 5, 3, 20, 20);
    run_phase(35, 35, 1'b0, 50);

    set_all(10, 10, 256, 256, 4, 2, 8, 4096);
    stall_pct = 0;
    send(mk(OP_ARRIVAL, RT_GET, 32'h11, 0, 0, 2, 0, 0), 0);
    send(mk(OP_ARRIVAL, RT_SET, 32'h12, 3, 3, 0, 1, 0), 0);
    send(mk(OP_ARRIVAL, RT_SET, 32'h13, 200, 3, 0, 1, 0), 0);
    send(mk(OP_ARRIVAL, RT_GET, 32'h14, 0, 0, 2, 0, 0), 0);
    send(mk(OP_ARRIVAL, 4'd15, 32'h15, 0, 0, 0, 0, 0), 0);
    send(mk(OP_ARRIVAL, 4'd9, 32'h16, 0, 0, 0, 0, 0), 0);
    send(mk(OP_LINK_FAIL, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_CLEAN, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(OP_BATCH_DONE, 0, 0, 0, 0, 0, 0, 0), 0);
    drain();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
